// ===== src/tmr_pkg.sv =====
// Shared types, widths and helper functions for the torus route block.
// No dependencies; imported by every module of the block.
`default_nettype none

package tmr_pkg;

  localparam int MAX_DIMS   = 3;
  localparam int NODE_W     = 24;
  localparam int OWN_W      = 18;
  localparam int RAD_W      = 7;
  localparam int DCNT_W     = 2;
  localparam int PORT_W     = 7;
  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;
  localparam int DIV_STAGES = 3;

  // Register map, one word per register.
  typedef enum logic [2:0] {
    REG_OWN_SWITCH    = 3'd0,
    REG_CONCENTRATION = 3'd1,
    REG_DIM_COUNT     = 3'd2,
    REG_SIZE_DIM0     = 3'd3,
    REG_SIZE_DIM1     = 3'd4,
    REG_SIZE_DIM2     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [OWN_W-1:0]                   own_switch;
    logic [RAD_W-1:0]                   concentration;
    logic [DCNT_W-1:0]                  dim_count;
    logic [MAX_DIMS-1:0][RAD_W-1:0]     size;
  } cfg_t;

  typedef struct packed {
    logic              crossed;
    logic [DCNT_W-1:0] hop_dim;
  } hdr_t;

  // Side information that rides along with the coordinate dividers.
  typedef struct packed {
    hdr_t             hdr;
    logic [RAD_W-1:0] loc;
    logic             local_hit;
    logic [RAD_W-1:0] sx0;
  } grpb_sb_t;

  typedef struct packed {
    grpb_sb_t         b;
    logic [RAD_W-1:0] dx0;
    logic [RAD_W-1:0] sx1;
  } grpc_sb_t;

  typedef struct packed {
    grpc_sb_t         c;
    logic [RAD_W-1:0] dx1;
    logic [RAD_W-1:0] sx2;
  } grpd_sb_t;

  typedef struct packed {
    hdr_t                           hdr;
    logic [RAD_W-1:0]               loc;
    logic                           local_hit;
    logic [MAX_DIMS-1:0][RAD_W-1:0] sx;
    logic [MAX_DIMS-1:0][RAD_W-1:0] dx;
  } route_in_t;

  typedef struct packed {
    logic [PORT_W-1:0] out_port;
    logic              vc;
    logic              crossed;
    logic [DCNT_W-1:0] hop_dim;
    logic              route_error;
  } route_out_t;

  // A radix or concentration of zero behaves as one.
  function automatic logic [RAD_W-1:0] eff_radix(input logic [RAD_W-1:0] v);
    return (v == '0) ? RAD_W'(1) : v;
  endfunction

  function automatic logic [DCNT_W-1:0] clamp_dims(input logic [DCNT_W-1:0] dc);
    return (dc > DCNT_W'(MAX_DIMS)) ? DCNT_W'(MAX_DIMS) : dc;
  endfunction

endpackage

`default_nettype wire

// ===== src/tmr_cfg_regs.sv =====
// APB-style configuration registers of the torus route block.
// Depends on tmr_pkg for the register map and the configuration struct.
`default_nettype none

module tmr_cfg_regs (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [tmr_pkg::PADDR_W-1:0]   paddr,
  input  wire  [tmr_pkg::PDATA_W-1:0]   pwdata,
  output logic [tmr_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output tmr_pkg::cfg_t                 cfg_o
);
  import tmr_pkg::*;

  cfg_t     cfg_q;
  cfg_reg_e reg_sel;
  logic     wr_en;

  assign reg_sel = cfg_reg_e'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_switch    <= '0;
      cfg_q.concentration <= RAD_W'(1);
      cfg_q.dim_count     <= DCNT_W'(3);
      cfg_q.size          <= {MAX_DIMS{RAD_W'(4)}};
    end else if (wr_en) begin
      case (reg_sel)
        REG_OWN_SWITCH:    cfg_q.own_switch    <= pwdata[OWN_W-1:0];
        REG_CONCENTRATION: cfg_q.concentration <= pwdata[RAD_W-1:0];
        REG_DIM_COUNT:     cfg_q.dim_count     <= pwdata[DCNT_W-1:0];
        REG_SIZE_DIM0:     cfg_q.size[0]       <= pwdata[RAD_W-1:0];
        REG_SIZE_DIM1:     cfg_q.size[1]       <= pwdata[RAD_W-1:0];
        REG_SIZE_DIM2:     cfg_q.size[2]       <= pwdata[RAD_W-1:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_OWN_SWITCH:    prdata = PDATA_W'(cfg_q.own_switch);
      REG_CONCENTRATION: prdata = PDATA_W'(cfg_q.concentration);
      REG_DIM_COUNT:     prdata = PDATA_W'(cfg_q.dim_count);
      REG_SIZE_DIM0:     prdata = PDATA_W'(cfg_q.size[0]);
      REG_SIZE_DIM1:     prdata = PDATA_W'(cfg_q.size[1]);
      REG_SIZE_DIM2:     prdata = PDATA_W'(cfg_q.size[2]);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/tmr_div_pipe.sv =====
// Pipelined restoring divider, several lanes sharing one valid and side bus.
// Depends on tmr_pkg for the radix width.
`default_nettype none

module tmr_div_pipe #(
  parameter int W      = tmr_pkg::NODE_W,
  parameter int STAGES = tmr_pkg::DIV_STAGES,
  parameter int LANES  = 2,
  parameter int SB_W   = 1
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          adv_i,
  input  wire                          valid_i,
  input  wire  [W-1:0]                 num_i [LANES],
  input  wire  [tmr_pkg::RAD_W-1:0]    den_i [LANES],
  input  wire  [SB_W-1:0]              sb_i,
  output logic                         valid_o,
  output logic [W-1:0]                 quo_o [LANES],
  output logic [tmr_pkg::RAD_W-1:0]    rem_o [LANES],
  output logic [SB_W-1:0]              sb_o
);
  import tmr_pkg::*;

  // Each stage handles up to STEPS quotient bits; the last stages may do fewer.
  localparam int STEPS = (W + STAGES - 1) / STAGES;
  localparam int REM_W = RAD_W + 1;
  localparam int WK_W  = REM_W + W;

  // Remainder sits in the top REM_W bits, quotient bits shift in from the bottom.
  function automatic logic [WK_W-1:0] div_steps(input logic [WK_W-1:0] w_in,
                                                input logic [RAD_W-1:0] den,
                                                input int n);
    logic [WK_W-1:0] w;
    w = w_in;
    for (int i = 0; i < STEPS; i++) begin
      if (i < n) begin
        w = {w[WK_W-2:0], 1'b0};
        if (w[WK_W-1 -: REM_W] >= {1'b0, den}) begin
          w[WK_W-1 -: REM_W] = w[WK_W-1 -: REM_W] - {1'b0, den};
          w[0] = 1'b1;
        end
      end
    end
    return w;
  endfunction

  logic [WK_W-1:0]   work_q [STAGES][LANES];
  logic [SB_W-1:0]   sb_q   [STAGES];
  logic [STAGES-1:0] valid_q;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [WK_W-1:0] src   [LANES];
    logic [WK_W-1:0] work_d[LANES];
    logic [SB_W-1:0] sb_d;
    logic            valid_d;

    if (s == 0) begin : g_first
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign src[l] = {{REM_W{1'b0}}, num_i[l]};
      end
      assign sb_d    = sb_i;
      assign valid_d = valid_i;
    end else begin : g_next
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign src[l] = work_q[s-1][l];
      end
      assign sb_d    = sb_q[s-1];
      assign valid_d = valid_q[s-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_calc
      assign work_d[l] = div_steps(src[l], den_i[l], W - s * STEPS);

      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          work_q[s][l] <= work_d[l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        sb_q[s] <= sb_d;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (adv_i) begin
        valid_q[s] <= valid_d;
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quo_o[l] = work_q[STAGES-1][l][W-1:0];
    assign rem_o[l] = work_q[STAGES-1][l][W +: RAD_W];
  end

  assign valid_o = valid_q[STAGES-1];
  assign sb_o    = sb_q[STAGES-1];

endmodule

`default_nettype wire

// ===== src/tmr_route_sel.sv =====
// Final two stages: per-dimension ring direction and dateline checks, then
// lowest-dimension selection into the output register. Depends on tmr_pkg.
`default_nettype none

module tmr_route_sel (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    adv_i,
  input  wire                    valid_i,
  input  tmr_pkg::route_in_t     route_i,
  input  tmr_pkg::cfg_t          cfg_i,
  output logic                   valid_o,
  output tmr_pkg::route_out_t    route_o
);
  import tmr_pkg::*;

  typedef struct packed {
    hdr_t                  hdr;
    logic                  local_hit;
    logic [PORT_W-1:0]     local_port;
    logic [MAX_DIMS-1:0]   diff;
    logic [MAX_DIMS-1:0]   pos;
    logic [MAX_DIMS-1:0]   wrap;
  } dim_flags_t;

  dim_flags_t        flags_d, flags_q;
  logic              flags_vld_q;
  route_out_t        res_d, res_q;
  logic              res_vld_q;
  logic [DCNT_W-1:0] ndim;

  assign ndim = clamp_dims(cfg_i.dim_count);

  always_comb begin
    flags_d.hdr        = route_i.hdr;
    flags_d.local_hit  = route_i.local_hit;
    flags_d.local_port = route_i.loc + PORT_W'({ndim, 1'b0});
    for (int d = 0; d < MAX_DIMS; d++) begin : g_dim
      logic [RAD_W-1:0] k;
      logic [RAD_W-1:0] sx;
      logic [RAD_W-1:0] dx;
      logic [RAD_W:0]   fwd;
      k  = eff_radix(cfg_i.size[d]);
      sx = route_i.sx[d];
      dx = route_i.dx[d];
      if (dx >= sx) begin
        fwd = {1'b0, dx} - {1'b0, sx};
      end else begin
        fwd = {1'b0, dx} + {1'b0, k} - {1'b0, sx};
      end
      flags_d.diff[d] = (DCNT_W'(d) < ndim) && (sx != dx);
      // Ties between the two ring directions go positive.
      flags_d.pos[d]  = {fwd, 1'b0} <= {2'b00, k};
      flags_d.wrap[d] = flags_d.pos[d] ? (sx == k - RAD_W'(1)) : (sx == '0);
    end
  end

  always_comb begin
    logic              found;
    logic [DCNT_W-1:0] sel;
    found = 1'b0;
    sel   = '0;
    for (int d = MAX_DIMS - 1; d >= 0; d--) begin
      if (flags_q.diff[d]) begin
        found = 1'b1;
        sel   = DCNT_W'(d);
      end
    end

    res_d.out_port    = '0;
    res_d.vc          = 1'b0;
    res_d.crossed     = flags_q.hdr.crossed;
    res_d.hop_dim     = flags_q.hdr.hop_dim;
    res_d.route_error = 1'b0;
    if (flags_q.local_hit) begin
      res_d.out_port = flags_q.local_port;
    end else if (found) begin
      res_d.out_port = PORT_W'({sel, !flags_q.pos[sel]});
      res_d.hop_dim  = sel;
      if (flags_q.wrap[sel]) begin
        res_d.vc      = 1'b1;
        res_d.crossed = 1'b1;
      end else if (sel != flags_q.hdr.hop_dim) begin
        res_d.vc      = 1'b0;
        res_d.crossed = 1'b0;
      end else begin
        res_d.vc      = flags_q.hdr.crossed;
        res_d.crossed = flags_q.hdr.crossed;
      end
    end else begin
      res_d.route_error = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      flags_q <= flags_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_vld_q <= 1'b0;
      res_vld_q   <= 1'b0;
    end else if (adv_i) begin
      flags_vld_q <= valid_i;
      res_vld_q   <= flags_vld_q;
    end
  end

  assign valid_o = res_vld_q;
  assign route_o = res_q;

endmodule

`default_nettype wire

// ===== src/torus_minimal_route_dateline_vc_top.sv =====
// Torus minimal route computation with dateline virtual channels, top level.
// Headers flow through restoring divider groups A to D, then tmr_route_sel.
// Throughput is one header per cycle while the output is not stalled.
// Reset (async, active low) empties the pipeline and loads register defaults.
// Depends on tmr_pkg, tmr_cfg_regs, tmr_div_pipe and tmr_route_sel.
`default_nettype none

module torus_minimal_route_dateline_vc_top #(
  parameter int DIV_STAGES = tmr_pkg::DIV_STAGES
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // Configuration port.
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [tmr_pkg::PADDR_W-1:0]   paddr,
  input  wire  [tmr_pkg::PDATA_W-1:0]   pwdata,
  output logic [tmr_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // Header input channel.
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire  [tmr_pkg::NODE_W-1:0]    dest_node_i,
  input  wire                           crossed_in_i,
  input  wire  [tmr_pkg::DCNT_W-1:0]    last_dim_in_i,
  // Routing decision output channel.
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [tmr_pkg::PORT_W-1:0]    out_port_o,
  output logic                          vc_o,
  output logic                          crossed_out_o,
  output logic [tmr_pkg::DCNT_W-1:0]    last_dim_out_o,
  output logic                          route_error_o
);
  import tmr_pkg::*;

  // The whole pipeline moves as one. It holds only when the output register
  // has a result that the consumer is stalling; a stalled output then also
  // stalls the input side so that no transfer is lost or repeated.
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  cfg_t cfg;

  tmr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Effective divisors. Configuration is to change only while the block is idle;
  // the block itself does not enforce this. Every stage reads them directly.
  logic [RAD_W-1:0] conc_k, k0, k1, k2;
  assign conc_k = eff_radix(cfg.concentration);
  assign k0     = eff_radix(cfg.size[0]);
  assign k1     = eff_radix(cfg.size[1]);
  assign k2     = eff_radix(cfg.size[2]);

  // Group A: destination switch and local endpoint from the node address,
  // while the second lane peels coordinate zero off this switch's address.
  logic             a_valid;
  logic [NODE_W-1:0] a_num [2];
  logic [RAD_W-1:0]  a_den [2];
  logic [NODE_W-1:0] a_quo [2];
  logic [RAD_W-1:0]  a_rem [2];
  hdr_t              a_sb_in, a_sb;

  assign a_num[0]         = dest_node_i;
  assign a_den[0]         = conc_k;
  assign a_num[1]         = NODE_W'(cfg.own_switch);
  assign a_den[1]         = k0;
  assign a_sb_in.crossed  = crossed_in_i;
  assign a_sb_in.hop_dim  = last_dim_in_i;

  tmr_div_pipe #(
    .W      (NODE_W),
    .STAGES (DIV_STAGES),
    .LANES  (2),
    .SB_W   ($bits(hdr_t))
  ) u_div_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .num_i   (a_num),
    .den_i   (a_den),
    .sb_i    (a_sb_in),
    .valid_o (a_valid),
    .quo_o   (a_quo),
    .rem_o   (a_rem),
    .sb_o    (a_sb)
  );

  // Group B: coordinate zero of the destination, coordinate one of this switch.
  // The local ejection check rides along from here on.
  logic              b_valid;
  logic [NODE_W-1:0] b_num [2];
  logic [RAD_W-1:0]  b_den [2];
  logic [NODE_W-1:0] b_quo [2];
  logic [RAD_W-1:0]  b_rem [2];
  grpb_sb_t          b_sb_in, b_sb;

  assign b_num[0]          = a_quo[0];
  assign b_den[0]          = k0;
  assign b_num[1]          = a_quo[1];
  assign b_den[1]          = k1;
  assign b_sb_in.hdr       = a_sb;
  assign b_sb_in.loc       = a_rem[0];
  assign b_sb_in.local_hit = (a_quo[0] == NODE_W'(cfg.own_switch));
  assign b_sb_in.sx0       = a_rem[1];

  tmr_div_pipe #(
    .W      (NODE_W),
    .STAGES (DIV_STAGES),
    .LANES  (2),
    .SB_W   ($bits(grpb_sb_t))
  ) u_div_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (a_valid),
    .num_i   (b_num),
    .den_i   (b_den),
    .sb_i    (b_sb_in),
    .valid_o (b_valid),
    .quo_o   (b_quo),
    .rem_o   (b_rem),
    .sb_o    (b_sb)
  );

  // Group C: coordinate one of the destination, coordinate two of this switch.
  logic              c_valid;
  logic [NODE_W-1:0] c_num [2];
  logic [RAD_W-1:0]  c_den [2];
  logic [NODE_W-1:0] c_quo [2];
  logic [RAD_W-1:0]  c_rem [2];
  grpc_sb_t          c_sb_in, c_sb;

  assign c_num[0]    = b_quo[0];
  assign c_den[0]    = k1;
  assign c_num[1]    = b_quo[1];
  assign c_den[1]    = k2;
  assign c_sb_in.b   = b_sb;
  assign c_sb_in.dx0 = b_rem[0];
  assign c_sb_in.sx1 = b_rem[1];

  tmr_div_pipe #(
    .W      (NODE_W),
    .STAGES (DIV_STAGES),
    .LANES  (2),
    .SB_W   ($bits(grpc_sb_t))
  ) u_div_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (b_valid),
    .num_i   (c_num),
    .den_i   (c_den),
    .sb_i    (c_sb_in),
    .valid_o (c_valid),
    .quo_o   (c_quo),
    .rem_o   (c_rem),
    .sb_o    (c_sb)
  );

  // Group D: coordinate two of the destination. Only the remainder matters.
  logic              d_valid;
  logic [NODE_W-1:0] d_num [1];
  logic [RAD_W-1:0]  d_den [1];
  logic [RAD_W-1:0]  d_rem [1];
  grpd_sb_t          d_sb_in, d_sb;

  assign d_num[0]    = c_quo[0];
  assign d_den[0]    = k2;
  assign d_sb_in.c   = c_sb;
  assign d_sb_in.dx1 = c_rem[0];
  assign d_sb_in.sx2 = c_rem[1];

  tmr_div_pipe #(
    .W      (NODE_W),
    .STAGES (DIV_STAGES),
    .LANES  (1),
    .SB_W   ($bits(grpd_sb_t))
  ) u_div_d (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (c_valid),
    .num_i   (d_num),
    .den_i   (d_den),
    .sb_i    (d_sb_in),
    .valid_o (d_valid),
    .quo_o   (),
    .rem_o   (d_rem),
    .sb_o    (d_sb)
  );

  // Gather both coordinate sets for the decision stages.
  route_in_t  route_in;
  route_out_t route_out;

  assign route_in.hdr       = d_sb.c.b.hdr;
  assign route_in.loc       = d_sb.c.b.loc;
  assign route_in.local_hit = d_sb.c.b.local_hit;
  assign route_in.sx[0]     = d_sb.c.b.sx0;
  assign route_in.sx[1]     = d_sb.c.sx1;
  assign route_in.sx[2]     = d_sb.sx2;
  assign route_in.dx[0]     = d_sb.c.dx0;
  assign route_in.dx[1]     = d_sb.dx1;
  assign route_in.dx[2]     = d_rem[0];

  tmr_route_sel u_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (d_valid),
    .route_i (route_in),
    .cfg_i   (cfg),
    .valid_o (out_valid_o),
    .route_o (route_out)
  );

  assign out_port_o     = route_out.out_port;
  assign vc_o           = route_out.vc;
  assign crossed_out_o  = route_out.crossed;
  assign last_dim_out_o = route_out.hop_dim;
  assign route_error_o  = route_out.route_error;

  // An error result carries no port and the base virtual channel.
  a_error_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && route_error_o |-> (out_port_o == '0) && !vc_o)
    else $error("route error result with port or vc set");

  // The dateline channel is only used once the crossed flag is set.
  a_vc_implies_crossed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && vc_o |-> crossed_out_o)
    else $error("vc 1 chosen without crossed flag");

  // The input side only holds off while a finished result waits to be taken.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output free");

endmodule

`default_nettype wire
